### design/nfmp_pkg.sv
// Package for the nearest feasible material projection unit.
// Holds the controller state type, register and operation codes and shared widths.
// No dependencies.
`timescale 1ns / 1ps

package nfmp_pkg;

    localparam int ENERGY_W = 160;
    localparam int CFG_AW   = 3;
    localparam int S_DW     = 104;
    localparam int M_DW     = 104;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_LOAD  = 5'b10000
    } t_state;

    typedef enum logic [CFG_AW-1:0] {
        CFG_COEF_STRETCH = 3'd0,
        CFG_COEF_BEND    = 3'd1,
        CFG_ENTRIES_USED = 3'd2,
        CFG_STRETCH_LOW  = 3'd3,
        CFG_STRETCH_HIGH = 3'd4,
        CFG_CURV_LOW     = 3'd5,
        CFG_CURV_HIGH    = 3'd6
    } t_cfg_reg;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

endpackage

### design/nfmp_table.sv
// Material table: one write port and one registered read port.
// Entry layout from bit 0: stretch, curvature, first and second process value.
`timescale 1ns / 1ps

module nfmp_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/nfmp_energy.sv
// Pipelined energy distance cells, one table entry enters per cycle.
// Each stage holds one step of the exact distance; uses nfmp_pkg for widths.
`timescale 1ns / 1ps

module nfmp_energy #(
    parameter int AW = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [AW-1:0]                  i_idx,
    input  logic [15:0]                    i_es,
    input  logic signed [15:0]             i_ek,
    input  logic [31:0]                    i_qs2,
    input  logic signed [15:0]             i_qk,
    input  logic [31:0]                    i_coef_a,
    input  logic [31:0]                    i_coef_b,
    output logic                           o_valid,
    output logic [AW-1:0]                  o_idx,
    output logic [nfmp_pkg::ENERGY_W-1:0]  o_dist,
    output logic                           o_busy
);

    localparam int NST = 9;

    logic          r_v  [NST];
    logic [AW-1:0] r_ix [NST];

    logic signed [16:0] w_dk;
    logic [16:0]        w_dk_abs;
    logic [31:0]        r1_es2, r1_dk2;
    logic [31:0]        r2_dl, r2_es2;
    logic [63:0]        r2_bt;
    logic [63:0]        r3_dl2, r3_bt;
    logic [31:0]        r3_es2;
    logic [63:0]        r4_p0, r4_p1, r4_bt;
    logic [31:0]        r4_es2;
    logic [95:0]        r5_at;
    logic [63:0]        r5_bt;
    logic [31:0]        r5_es2;
    logic [127:0]       r6_sm;
    logic [31:0]        r6_es2;
    logic [63:0]        r7_pp [4];
    logic [95:0]        r8_q01, r8_q23;
    logic [nfmp_pkg::ENERGY_W-1:0] r9_d;
    logic               w_busy;

    assign w_dk     = 17'(i_qk) - 17'(i_ek);
    assign w_dk_abs = w_dk[16] ? 17'(-w_dk) : 17'(w_dk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int i = 1; i < NST; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ix[0] <= i_idx;
        for (int i = 1; i < NST; i++) begin
            r_ix[i] <= r_ix[i-1];
        end

        r1_es2 <= 32'(i_es) * 32'(i_es);
        r1_dk2 <= 32'(w_dk_abs[15:0]) * 32'(w_dk_abs[15:0]);

        r2_dl  <= (i_qs2 >= r1_es2) ? (i_qs2 - r1_es2) : (r1_es2 - i_qs2);
        r2_bt  <= 64'(r1_dk2) * 64'(i_coef_b);
        r2_es2 <= r1_es2;

        r3_dl2 <= 64'(r2_dl) * 64'(r2_dl);
        r3_bt  <= r2_bt;
        r3_es2 <= r2_es2;

        r4_p0  <= 64'(r3_dl2[31:0]) * 64'(i_coef_a);
        r4_p1  <= 64'(r3_dl2[63:32]) * 64'(i_coef_a);
        r4_bt  <= r3_bt;
        r4_es2 <= r3_es2;

        r5_at  <= 96'(r4_p0) + (96'(r4_p1) << 32);
        r5_bt  <= r4_bt;
        r5_es2 <= r4_es2;

        r6_sm  <= 128'(r5_at) + (128'(r5_bt) << 40);
        r6_es2 <= r5_es2;

        for (int j = 0; j < 4; j++) begin
            r7_pp[j] <= 64'(r6_sm[32*j +: 32]) * 64'(r6_es2);
        end

        r8_q01 <= 96'(r7_pp[0]) + (96'(r7_pp[1]) << 32);
        r8_q23 <= 96'(r7_pp[2]) + (96'(r7_pp[3]) << 32);

        r9_d <= nfmp_pkg::ENERGY_W'(r8_q01) + (nfmp_pkg::ENERGY_W'(r8_q23) << 64);
    end

    always_comb begin
        w_busy = 1'b0;
        for (int i = 0; i < NST; i++) begin
            w_busy = w_busy | r_v[i];
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_idx   = r_ix[NST-1];
    assign o_dist  = r9_d;
    assign o_busy  = w_busy;

endmodule

### design/nfmp_best.sv
// Running minimum cell: keeps the least distance and its index over a scan.
// Uses nfmp_pkg for the distance width.
`timescale 1ns / 1ps

module nfmp_best #(
    parameter int AW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_valid,
    input  logic [AW-1:0]                 i_idx,
    input  logic [nfmp_pkg::ENERGY_W-1:0] i_dist,
    output logic                          o_have,
    output logic [AW-1:0]                 o_idx
);

    logic                          r_have;
    logic [AW-1:0]                 r_idx;
    logic [nfmp_pkg::ENERGY_W-1:0] r_dist;
    logic                          w_take;

    assign w_take = i_valid && (!r_have || (i_dist < r_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (w_take) begin
            r_have <= 1'b1;
            r_idx  <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dist <= i_dist;
        end
    end

    assign o_have = r_have;
    assign o_idx  = r_idx;

endmodule

### design/nearest_feasible_material_project_unit.sv
// Nearest feasible material projection unit, top level.
// A query reads one scanned entry per cycle into the nine-stage energy pipeline, waits
// for it to drain, fetches the best entry and loads the result; a new query or write is
// accepted only once the previous query's result has been loaded.
// Reset is synchronous and active low; configuration returns to its reset values and
// the table contents are undefined until written. Uses nfmp_pkg and the nfmp modules.
`timescale 1ns / 1ps

module nearest_feasible_material_project_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [nfmp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // entry_index, entry_stretch, entry_curv, entry_first_param, entry_second_param,
    // query_stretch, query_curv
    input  logic [nfmp_pkg::S_DW-1:0]   i_s_tdata,
    // func
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // best_index, best_stretch, best_curv, best_first_param, best_second_param,
    // stretch_excess, curv_excess
    output logic [nfmp_pkg::M_DW-1:0]   o_m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;

    nfmp_pkg::t_state r_state, n_state;

    logic [31:0]        r_coef_a, r_coef_b;
    logic [8:0]         r_entries;
    logic [15:0]        r_str_low, r_str_high;
    logic signed [15:0] r_curv_low, r_curv_high;

    logic [15:0]        r_qs;
    logic signed [15:0] r_qk;
    logic [31:0]        r_qs2;
    logic [CW-1:0]      r_n, r_cnt;
    logic               r_rv;
    logic [AW-1:0]      r_rix;
    logic               r_m_valid;
    logic [nfmp_pkg::M_DW-1:0] r_m_data;

    logic               w_s_acc, w_write, w_query, w_issue, w_re, w_wr_ok, w_load;
    logic [31:0]        w_n32;
    logic [AW-1:0]      w_raddr;
    logic [63:0]        w_rdata, w_fields;
    logic               w_e_valid, w_busy, w_have;
    logic [AW-1:0]      w_e_idx, w_best_idx;
    logic [nfmp_pkg::ENERGY_W-1:0] w_dist;
    logic signed [17:0] w_sx_hi, w_sx_lo, w_sx;
    logic signed [17:0] w_cx_hi, w_cx_lo, w_cx;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == nfmp_pkg::ST_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_write     = w_s_acc && (i_s_tuser == nfmp_pkg::FUNC_WRITE);
    assign w_query     = w_s_acc && (i_s_tuser == nfmp_pkg::FUNC_QUERY);
    assign w_wr_ok     = w_write && (32'(i_s_tdata[7:0]) < 32'(TABLE_DEPTH));
    assign w_n32       = (32'(r_entries) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                              : 32'(r_entries);
    assign w_issue     = (r_state == nfmp_pkg::ST_SCAN) && (r_cnt < r_n);
    assign w_re        = w_issue || (r_state == nfmp_pkg::ST_FETCH);
    assign w_raddr     = w_issue ? r_cnt[AW-1:0] : w_best_idx;
    assign w_load      = (r_state == nfmp_pkg::ST_LOAD) && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a    <= '0;
            r_coef_b    <= '0;
            r_entries   <= '0;
            r_str_low   <= '0;
            r_str_high  <= 16'hFFFF;
            r_curv_low  <= 16'sh8000;
            r_curv_high <= 16'sh7FFF;
        end else if (i_cfg_valid) begin
            unique case (nfmp_pkg::t_cfg_reg'(i_cfg_addr))
                nfmp_pkg::CFG_COEF_STRETCH: r_coef_a    <= i_cfg_data;
                nfmp_pkg::CFG_COEF_BEND:    r_coef_b    <= i_cfg_data;
                nfmp_pkg::CFG_ENTRIES_USED: r_entries   <= i_cfg_data[8:0];
                nfmp_pkg::CFG_STRETCH_LOW:  r_str_low   <= i_cfg_data[15:0];
                nfmp_pkg::CFG_STRETCH_HIGH: r_str_high  <= i_cfg_data[15:0];
                nfmp_pkg::CFG_CURV_LOW:     r_curv_low  <= $signed(i_cfg_data[15:0]);
                nfmp_pkg::CFG_CURV_HIGH:    r_curv_high <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nfmp_pkg::ST_IDLE:  if (w_query) n_state = nfmp_pkg::ST_SCAN;
            nfmp_pkg::ST_SCAN:  if (r_cnt >= r_n) n_state = nfmp_pkg::ST_DRAIN;
            nfmp_pkg::ST_DRAIN: if (!r_rv && !w_busy) n_state = nfmp_pkg::ST_FETCH;
            nfmp_pkg::ST_FETCH: n_state = nfmp_pkg::ST_LOAD;
            nfmp_pkg::ST_LOAD:  if (w_load) n_state = nfmp_pkg::ST_IDLE;
            default:            n_state = nfmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfmp_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_n       <= '0;
            r_rv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= w_issue;
            if (w_query) begin
                r_cnt <= '0;
                r_n   <= CW'(w_n32);
            end else if (w_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qs  <= i_s_tdata[87:72];
            r_qk  <= $signed(i_s_tdata[103:88]);
            r_qs2 <= 32'(i_s_tdata[87:72]) * 32'(i_s_tdata[87:72]);
        end
        if (w_issue) begin
            r_rix <= r_cnt[AW-1:0];
        end
        if (w_load) begin
            r_m_data <= {w_cx[15:0], w_sx[15:0], w_fields, 8'(w_best_idx)};
        end
    end

    assign w_fields = w_have ? w_rdata : 64'd0;

    assign w_sx_hi = 18'(r_qs) - 18'(r_str_high);
    assign w_sx_lo = 18'(r_str_low) - 18'(r_qs);
    assign w_cx_hi = 18'(r_qk) - 18'(r_curv_high);
    assign w_cx_lo = 18'(r_curv_low) - 18'(r_qk);

    always_comb begin
        w_sx = 18'sd0;
        if (w_sx_hi > w_sx) w_sx = w_sx_hi;
        if (w_sx_lo > w_sx) w_sx = w_sx_lo;
        w_cx = 18'sd0;
        if (w_cx_hi > w_cx) w_cx = w_cx_hi;
        if (w_cx_lo > w_cx) w_cx = w_cx_lo;
    end

    nfmp_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_ok),
        .i_waddr (AW'(i_s_tdata[7:0])),
        .i_wdata (i_s_tdata[71:8]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nfmp_energy #(
        .AW (AW)
    ) u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rv),
        .i_idx    (r_rix),
        .i_es     (w_rdata[15:0]),
        .i_ek     ($signed(w_rdata[31:16])),
        .i_qs2    (r_qs2),
        .i_qk     (r_qk),
        .i_coef_a (r_coef_a),
        .i_coef_b (r_coef_b),
        .o_valid  (w_e_valid),
        .o_idx    (w_e_idx),
        .o_dist   (w_dist),
        .o_busy   (w_busy)
    );

    nfmp_best #(
        .AW (AW)
    ) u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_query),
        .i_valid (w_e_valid),
        .i_idx   (w_e_idx),
        .i_dist  (w_dist),
        .o_have  (w_have),
        .o_idx   (w_best_idx)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef ASSERT_OFF
    a_no_energy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfmp_pkg::ST_IDLE) |-> !w_e_valid)
        else $error("Energy result seen while idle.");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfmp_pkg::ST_LOAD) |-> (!w_busy && !r_rv))
        else $error("Result loaded before the pipeline drained.");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_have |-> (32'(w_best_idx) < 32'(r_n)))
        else $error("Chosen index outside the scanned range.");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfmp_pkg::ST_DRAIN) |-> (r_cnt == r_n))
        else $error("Scan left before every entry was read.");
`endif

endmodule
